// ===== src/dssp_pkg.sv =====
// Package for the decimal size suffix parser.
// Holds the parse phase type, status codes, character codes and the suffix decoder.
// Depends on nothing.
`default_nettype none

package dssp_pkg;

   typedef enum logic [6:0] {
      PH_START  = 7'b0000001,
      PH_SPACE  = 7'b0000010,
      PH_SIGNED = 7'b0000100,
      PH_DIGITS = 7'b0001000,
      PH_SUFFIX = 7'b0010000,
      PH_DEAD   = 7'b0100000,
      PH_JUNK   = 7'b1000000
   } phase_type;

   typedef logic [1:0] status_type;

   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_INVALID   = 2'd1;
   localparam status_type ST_OVERFLOW  = 2'd2;
   localparam status_type ST_SCALE_OVF = 2'd3;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;

   // Largest accumulator value that can still take one more digit.
   localparam logic [63:0] LIMIT_DIV10 = 64'd1844674407370955161;

   typedef struct packed {
      logic       hit;
      logic [5:0] shift;
   } suffix_type;

   // Decode a case-insensitive size letter into its power-of-1024 shift.
   function automatic suffix_type suffix_decode(input logic [7:0] c);
      suffix_type r;
      logic [7:0] lc;
      lc = (c >= 8'h41 && c <= 8'h5A) ? (c + 8'd32) : c;
      r.hit   = 1'b1;
      r.shift = 6'd0;
      case (lc)
         8'h65: r.shift = 6'd60;  // e
         8'h70: r.shift = 6'd50;  // p
         8'h74: r.shift = 6'd40;  // t
         8'h67: r.shift = 6'd30;  // g
         8'h6D: r.shift = 6'd20;  // m
         8'h6B: r.shift = 6'd10;  // k
         8'h62: r.shift = 6'd0;   // b
         default: r.hit = 1'b0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== src/decimal_size_suffix_parser.sv =====
// Top level of the decimal size suffix parser: byte stream in, one result per string out.
// Depends on dssp_pkg.
`default_nettype none

// Parses a zero-terminated decimal string, one character per word on the req_ channel,
// following strtoull rules in base 10: leading whitespace is skipped, one optional sign
// is taken (a minus as the very first byte makes the string invalid, a minus after
// whitespace negates modulo 2^64), digits accumulate with overflow detection, and one
// optional case-insensitive suffix K, M, G, T, P, E or B scales by a power of 1024.
// The zero byte closes the string and yields exactly one rsp_ word carrying the scaled
// value and a status: 0 ok, 1 invalid syntax, 2 value overflow, 3 scaled overflow; the
// value reads 0 whenever status is not 0. Rate: one character per clock, sustained unless
// a zero byte waits behind an unaccepted result. Each word passes an input register, then
// a state update (multiply by ten and add, limit compare, or the final negate, range check
// and shift) that writes the parser state or the result register. The input register also
// absorbs a stalled result, so req_tready drops only while a finished result waits and
// another zero byte is queued behind it.
module decimal_size_suffix_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] char_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata    // [63:0] parsed_value, [65:64] status, [71:66] zero
);

   // input register
   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_byte_ff, in_byte_in;

   // parser state
   dssp_pkg::phase_type   phase_ff, phase_in;
   logic [63:0]           acc_ff, acc_in;
   logic                  ovf_ff, ovf_in;
   logic                  neg_ff, neg_in;
   logic [5:0]            shift_ff, shift_in;
   logic                  bad_ff, bad_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [63:0]           rsp_value_ff, rsp_value_in;
   dssp_pkg::status_type  rsp_status_ff, rsp_status_in;

   logic                  is_nul, is_space, is_digit;
   logic                  step;      // the queued word is consumed this cycle
   logic                  finish;    // the queued word is the terminator
   logic [63:0]           digit;
   logic [63:0]           acc_next;
   logic                  acc_ovf;
   dssp_pkg::suffix_type  sfx;
   logic [63:0]           signed_val;
   logic [6:0]            spill_amt;
   logic                  scale_ovf;
   logic                  has_digits;

   // character classes of the queued word
   assign is_nul   = (in_byte_ff == dssp_pkg::CH_NUL);
   assign is_space = (in_byte_ff == dssp_pkg::CH_SPACE) ||
                     (in_byte_ff >= 8'h09 && in_byte_ff <= 8'h0D);
   assign is_digit = (in_byte_ff >= 8'h30 && in_byte_ff <= 8'h39);
   assign sfx      = dssp_pkg::suffix_decode(in_byte_ff);

   // A terminator needs a free result slot; any other byte always advances.
   assign step   = in_valid_ff && (!is_nul || !rsp_valid_ff || rsp_tready);
   assign finish = step && is_nul;

   assign req_tready = !in_valid_ff || step;

   // multiply by ten and add, with the strtoull limit check
   assign digit    = {56'd0, in_byte_ff - 8'h30};
   assign acc_ovf  = (acc_ff > dssp_pkg::LIMIT_DIV10) ||
                     (acc_ff == dssp_pkg::LIMIT_DIV10 && digit > 64'd5);
   assign acc_next = (acc_ff << 3) + (acc_ff << 1) + digit;

   // result path: negate, check bits that would spill past bit 63, scale
   assign has_digits = (phase_ff == dssp_pkg::PH_DIGITS) ||
                       (phase_ff == dssp_pkg::PH_SUFFIX) ||
                       (phase_ff == dssp_pkg::PH_JUNK);
   assign signed_val = neg_ff ? (64'd0 - acc_ff) : acc_ff;
   assign spill_amt  = 7'd64 - {1'b0, shift_ff};
   assign scale_ovf  = (shift_ff != 6'd0) && ((signed_val >> spill_amt) != 64'd0);

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      ovf_in   = ovf_ff;
      neg_in   = neg_ff;
      shift_in = shift_ff;
      bad_in   = bad_ff;
      if (finish) begin
         // return to the start of a new string
         phase_in = dssp_pkg::PH_START;
         acc_in   = 64'd0;
         ovf_in   = 1'b0;
         neg_in   = 1'b0;
         shift_in = 6'd0;
         bad_in   = 1'b0;
      end else if (step) begin
         case (phase_ff)
            dssp_pkg::PH_START, dssp_pkg::PH_SPACE: begin
               if (is_space) begin
                  phase_in = dssp_pkg::PH_SPACE;
               end else if (in_byte_ff == dssp_pkg::CH_PLUS) begin
                  phase_in = dssp_pkg::PH_SIGNED;
               end else if (in_byte_ff == dssp_pkg::CH_MINUS) begin
                  if (phase_ff == dssp_pkg::PH_START) begin
                     phase_in = dssp_pkg::PH_DEAD;
                  end else begin
                     neg_in   = 1'b1;
                     phase_in = dssp_pkg::PH_SIGNED;
                  end
               end else if (is_digit) begin
                  if (acc_ovf) ovf_in = 1'b1;
                  else         acc_in = acc_next;
                  phase_in = dssp_pkg::PH_DIGITS;
               end else begin
                  phase_in = dssp_pkg::PH_DEAD;
               end
            end
            dssp_pkg::PH_SIGNED: begin
               if (is_digit) begin
                  if (acc_ovf) ovf_in = 1'b1;
                  else         acc_in = acc_next;
                  phase_in = dssp_pkg::PH_DIGITS;
               end else begin
                  phase_in = dssp_pkg::PH_DEAD;
               end
            end
            dssp_pkg::PH_DIGITS: begin
               if (is_digit) begin
                  if (acc_ovf) ovf_in = 1'b1;
                  else         acc_in = acc_next;
               end else if (sfx.hit) begin
                  shift_in = sfx.shift;
                  phase_in = dssp_pkg::PH_SUFFIX;
               end else begin
                  bad_in   = 1'b1;
                  phase_in = dssp_pkg::PH_JUNK;
               end
            end
            dssp_pkg::PH_SUFFIX, dssp_pkg::PH_JUNK: begin
               // anything after the suffix or after junk spoils the string
               bad_in   = 1'b1;
               phase_in = dssp_pkg::PH_JUNK;
            end
            default: begin
               phase_in = dssp_pkg::PH_DEAD;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = 64'd0;
         if (!has_digits) begin
            rsp_status_in = dssp_pkg::ST_INVALID;
         end else if (ovf_ff) begin
            rsp_status_in = dssp_pkg::ST_OVERFLOW;
         end else if (bad_ff) begin
            rsp_status_in = dssp_pkg::ST_INVALID;
         end else if (scale_ovf) begin
            rsp_status_in = dssp_pkg::ST_SCALE_OVF;
         end else begin
            rsp_status_in = dssp_pkg::ST_OK;
            rsp_value_in  = signed_val << shift_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= dssp_pkg::PH_START;
         acc_ff       <= 64'd0;
         ovf_ff       <= 1'b0;
         neg_ff       <= 1'b0;
         shift_ff     <= 6'd0;
         bad_ff       <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         acc_ff       <= acc_in;
         ovf_ff       <= ovf_in;
         neg_ff       <= neg_in;
         shift_ff     <= shift_in;
         bad_ff       <= bad_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff    <= in_byte_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_status_ff, rsp_value_ff};

   // A consumed terminator always leaves a result behind.
   a_finish_gives_result: assert property (@(posedge clock) disable iff (reset)
      finish |=> rsp_valid_ff)
      else $error("terminator consumed without a result");

   // A failed parse never carries a value.
   a_fail_zero_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != dssp_pkg::ST_OK) |-> (rsp_value_ff == 64'd0))
      else $error("nonzero value with failing status");

   // Overflow can only have been seen once digits were taken.
   a_ovf_needs_digits: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (phase_ff == dssp_pkg::PH_DIGITS || phase_ff == dssp_pkg::PH_SUFFIX ||
                  phase_ff == dssp_pkg::PH_JUNK))
      else $error("overflow flag outside digit phases");

   // Trailing-byte flag and junk phase go together.
   a_bad_is_junk: assert property (@(posedge clock) disable iff (reset)
      bad_ff |-> (phase_ff == dssp_pkg::PH_JUNK))
      else $error("syntax flag set outside junk phase");

endmodule

`default_nettype wire
